>>> rtl/c2ll_pkg.sv
// Shared widths, record types and the CORDIC arctangent constants.
package c2ll_pkg;

  // Port widths
  localparam int COMP_W = 32;
  localparam int EPS_W  = 31;
  localparam int LAT_W  = 28;
  localparam int LON_W  = 29;

  // Internal widths
  localparam int MAG_W    = 32;   // scaled component magnitude, up to 2^31
  localparam int SHIFT_W  = 5;
  localparam int SQ_W     = 64;   // squares and sums of squares
  localparam int E2_W     = 62;   // epsilon squared
  localparam int PROD_W   = 128;  // epsilon squared times length squared
  localparam int CORD_W   = 60;   // CORDIC x and y
  localparam int ANG_W    = 41;   // CORDIC angle, units of 2^-32 degree
  localparam int ROM_W    = 40;
  localparam int ANG_FRAC = 32;
  localparam int OUT_FRAC = 20;
  localparam int PRE_SH   = 24;   // CORDIC operand pre-scale
  localparam int TH_W     = 27;   // angle in [0, 90 deg]

  localparam int SQRT_STEPS   = 32;
  localparam int CORDIC_ITERS = 34;

  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic [E2_W-1:0]  E2_RESET  = E2_W'(1);

  localparam logic [TH_W-1:0]  DEG90  = TH_W'(90 << OUT_FRAC);
  localparam logic [LON_W-1:0] DEG180 = LON_W'(180 << OUT_FRAC);
  localparam logic [LON_W-1:0] DEG360 = LON_W'(360 << OUT_FRAC);

  localparam logic [63:0] PI_Q56 = 64'h03243F6A8885A308;

  typedef struct packed {
    logic zero;
    logic xneg;
    logic ypos;
    logic zneg;
    logic pole;
    logic ynear;
  } flags_t;

  typedef struct packed {
    flags_t flags;
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
  } ctx_t;

  typedef struct packed {
    ctx_t ctx;
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    flags_t flags;
    logic signed [CORD_W-1:0] lat_x;
    logic signed [CORD_W-1:0] lat_y;
    logic signed [ANG_W-1:0]  lat_ang;
    logic signed [CORD_W-1:0] lon_x;
    logic signed [CORD_W-1:0] lon_y;
    logic signed [ANG_W-1:0]  lon_ang;
  } cord_t;

  typedef logic [CORDIC_ITERS-1:0][ROM_W-1:0] atan_rom_t;

  // Shift-subtract long division, elaboration only
  function automatic logic [95:0] udiv96(input logic [95:0] n, input logic [63:0] d);
    logic [64:0] rem;
    logic [95:0] q;
    rem = '0;
    q   = '0;
    for (int b = 95; b >= 0; b--) begin
      rem = {rem[63:0], n[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, units of 2^-32, from the atan series in Q56 radians
  function automatic atan_rom_t build_atan_rom();
    atan_rom_t   t;
    longint      acc;
    int          k;
    int          e;
    logic [95:0] q;
    logic [63:0] num;
    t    = '0;
    t[0] = ROM_W'(45) << ANG_FRAC;
    for (int i = 1; i < CORDIC_ITERS; i++) begin
      acc = 0;
      k   = 0;
      e   = 56 - i;
      while (e >= 0) begin
        q = udiv96(96'(64'd1 << e), 64'(2 * k + 1));
        if ((k % 2) == 1) acc = acc - longint'(q[63:0]);
        else acc = acc + longint'(q[63:0]);
        k = k + 1;
        e = 56 - i * (2 * k + 1);
      end
      num  = 64'(acc) * 64'd180;
      q    = udiv96({num, 32'd0}, PI_Q56);
      t[i] = q[ROM_W-1:0];
    end
    return t;
  endfunction

  localparam atan_rom_t ATAN_ROM = build_atan_rom();

endpackage

>>> rtl/c2ll_front.sv
// Input register, normalization, squares and the exact epsilon tests.
module c2ll_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [c2ll_pkg::COMP_W-1:0] x_component,
  input  logic signed [c2ll_pkg::COMP_W-1:0] y_component,
  input  logic signed [c2ll_pkg::COMP_W-1:0] z_component,
  input  logic [c2ll_pkg::E2_W-1:0]          e2,
  output logic                               dout_valid,
  output c2ll_pkg::ctx_t                     dout_ctx,
  output logic [c2ll_pkg::SQ_W-1:0]          dout_r2
);
  import c2ll_pkg::*;

  logic v0, v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic accept;

  logic signed [COMP_W-1:0] x0, y0, z0;
  ctx_t c1, c2, c3, c4, c5, c6, c7, c8, c9;
  logic [MAG_W-1:0] m1;
  logic [SQ_W-1:0] ax2, ay2, az2;
  logic [SQ_W-1:0] r2_4, ay2_4, az2_4;
  logic [SQ_W-1:0] r2_5, ay2_5, len2;
  logic [SQ_W-1:0] r2_6, ay2_6, pp_ll, pp_lh, pp_hl, pp_hh;
  logic [SQ_W-1:0] r2_7, ay2_7, pp_ll7, pp_hh7;
  logic [SQ_W:0]   mid7;
  logic [SQ_W-1:0] r2_8, ay2_8;
  logic [PROD_W-1:0] prod8;
  logic [SQ_W-1:0] r2_9;

  logic [MAG_W-1:0] mx, my, mz, m01, mmax;
  logic [SHIFT_W-1:0] pos, sh;

  assign in_stall = v0 && !adv;
  assign accept   = in_valid && !in_stall;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else begin
      if (accept) v0 <= 1'b1;
      else if (adv) v0 <= 1'b0;
      if (adv) begin
        v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
        v6 <= v5; v7 <= v6; v8 <= v7; v9 <= v8;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (accept) begin
      x0 <= x_component;
      y0 <= y_component;
      z0 <= z_component;
    end
  end

  // Magnitudes and the largest of them
  always_comb begin
    mx   = x0[COMP_W-1] ? MAG_W'(-x0) : MAG_W'(x0);
    my   = y0[COMP_W-1] ? MAG_W'(-y0) : MAG_W'(y0);
    mz   = z0[COMP_W-1] ? MAG_W'(-z0) : MAG_W'(z0);
    m01  = (mx > my) ? mx : my;
    mmax = (m01 > mz) ? m01 : mz;
  end

  // Left shift that brings the largest magnitude to [2^30, 2^31]
  always_comb begin
    pos = '0;
    for (int i = 0; i < MAG_W - 1; i++) begin
      if (m1[i]) pos = SHIFT_W'(i);
    end
    if (m1[MAG_W-1] || m1[MAG_W-2]) sh = '0;
    else sh = SHIFT_W'(MAG_W - 2) - pos;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      c1.flags.zero  <= (x0 == '0) && (y0 == '0) && (z0 == '0);
      c1.flags.xneg  <= x0[COMP_W-1];
      c1.flags.ypos  <= !y0[COMP_W-1] && (y0 != '0);
      c1.flags.zneg  <= z0[COMP_W-1];
      c1.flags.pole  <= 1'b0;
      c1.flags.ynear <= 1'b0;
      c1.ax <= mx;
      c1.ay <= my;
      c1.az <= mz;
      m1    <= mmax;
      // stage 2: normalize
      c2.flags <= c1.flags;
      c2.ax    <= c1.ax << sh;
      c2.ay    <= c1.ay << sh;
      c2.az    <= c1.az << sh;
      // stage 3: squares
      c3  <= c2;
      ax2 <= SQ_W'(c2.ax) * SQ_W'(c2.ax);
      ay2 <= SQ_W'(c2.ay) * SQ_W'(c2.ay);
      az2 <= SQ_W'(c2.az) * SQ_W'(c2.az);
      // stage 4
      c4    <= c3;
      r2_4  <= ax2 + ay2;
      ay2_4 <= ay2;
      az2_4 <= az2;
      // stage 5: length squared
      c5    <= c4;
      r2_5  <= r2_4;
      ay2_5 <= ay2_4;
      len2  <= r2_4 + az2_4;
      // stage 6: partial products of e2 * len2
      c6    <= c5;
      r2_6  <= r2_5;
      ay2_6 <= ay2_5;
      pp_ll <= SQ_W'(e2[31:0]) * SQ_W'(len2[31:0]);
      pp_lh <= SQ_W'(e2[31:0]) * SQ_W'(len2[SQ_W-1:32]);
      pp_hl <= SQ_W'(e2[E2_W-1:32]) * SQ_W'(len2[31:0]);
      pp_hh <= SQ_W'(e2[E2_W-1:32]) * SQ_W'(len2[SQ_W-1:32]);
      // stage 7
      c7      <= c6;
      r2_7    <= r2_6;
      ay2_7   <= ay2_6;
      pp_ll7  <= pp_ll;
      pp_hh7  <= pp_hh;
      mid7    <= {1'b0, pp_lh} + {1'b0, pp_hl};
      // stage 8: full product
      c8    <= c7;
      r2_8  <= r2_7;
      ay2_8 <= ay2_7;
      prod8 <= {pp_hh7, pp_ll7} + {31'd0, mid7, 32'd0};
      // stage 9: pole and near-zero y tests
      c9.flags.zero  <= c8.flags.zero;
      c9.flags.xneg  <= c8.flags.xneg;
      c9.flags.ypos  <= c8.flags.ypos;
      c9.flags.zneg  <= c8.flags.zneg;
      c9.flags.pole  <= !({4'd0, r2_8, 60'd0} > prod8);
      c9.flags.ynear <= !({4'd0, ay2_8, 60'd0} > prod8);
      c9.ax          <= c8.ax;
      c9.ay          <= c8.ay;
      c9.az          <= c8.az;
      r2_9           <= r2_8;
    end
  end

  assign dout_valid = v9;
  assign dout_ctx   = c9;
  assign dout_r2    = r2_9;

endmodule

>>> rtl/c2ll_sqrt_cell.sv
// One step of the digit-by-digit integer square root.
module c2ll_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            din_valid,
  input  c2ll_pkg::sqrt_t din,
  output logic            dout_valid,
  output c2ll_pkg::sqrt_t dout
);
  import c2ll_pkg::*;

  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic [SQ_W-1:0] trial;
  sqrt_t nxt;
  sqrt_t q;
  logic  qv;

  // Trial subtract
  always_comb begin
    trial   = din.root + BIT;
    nxt.ctx = din.ctx;
    if (din.rem >= trial) begin
      nxt.rem  = din.rem - trial;
      nxt.root = (din.root >> 1) + BIT;
    end else begin
      nxt.rem  = din.rem;
      nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) qv <= 1'b0;
    else if (adv) qv <= din_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) q <= nxt;
  end

  assign dout_valid = qv;
  assign dout       = q;

endmodule

>>> rtl/c2ll_cordic_cell.sv
// One vectoring rotation for both the latitude and the longitude CORDIC.
module c2ll_cordic_cell #(
  parameter int ITER = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            din_valid,
  input  c2ll_pkg::cord_t din,
  output logic            dout_valid,
  output c2ll_pkg::cord_t dout
);
  import c2ll_pkg::*;

  localparam logic signed [ANG_W-1:0] STEP_ANG = ANG_W'(ATAN_ROM[ITER]);

  logic signed [CORD_W-1:0] lat_xs, lat_ys, lon_xs, lon_ys;
  cord_t nxt;
  cord_t q;
  logic  qv;

  always_comb begin
    lat_xs    = din.lat_x >>> ITER;
    lat_ys    = din.lat_y >>> ITER;
    lon_xs    = din.lon_x >>> ITER;
    lon_ys    = din.lon_y >>> ITER;
    nxt.flags = din.flags;
    // latitude rotation
    if (!din.lat_y[CORD_W-1]) begin
      nxt.lat_x   = din.lat_x + lat_ys;
      nxt.lat_y   = din.lat_y - lat_xs;
      nxt.lat_ang = din.lat_ang + STEP_ANG;
    end else begin
      nxt.lat_x   = din.lat_x - lat_ys;
      nxt.lat_y   = din.lat_y + lat_xs;
      nxt.lat_ang = din.lat_ang - STEP_ANG;
    end
    // longitude rotation
    if (!din.lon_y[CORD_W-1]) begin
      nxt.lon_x   = din.lon_x + lon_ys;
      nxt.lon_y   = din.lon_y - lon_xs;
      nxt.lon_ang = din.lon_ang + STEP_ANG;
    end else begin
      nxt.lon_x   = din.lon_x - lon_ys;
      nxt.lon_y   = din.lon_y + lon_xs;
      nxt.lon_ang = din.lon_ang - STEP_ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) qv <= 1'b0;
    else if (adv) qv <= din_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) q <= nxt;
  end

  assign dout_valid = qv;
  assign dout       = q;

endmodule

>>> rtl/c2ll_back.sv
// Angle rounding and clamping, quadrant fold and the output register.
module c2ll_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              din_valid,
  input  c2ll_pkg::cord_t                   din,
  output logic                              out_valid,
  output logic signed [c2ll_pkg::LAT_W-1:0] latitude,
  output logic [c2ll_pkg::LON_W-1:0]        longitude,
  output logic                              zero_vector
);
  import c2ll_pkg::*;

  localparam int RND_W = ANG_W - (ANG_FRAC - OUT_FRAC);
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(1) << (ANG_FRAC - OUT_FRAC - 1);

  logic signed [ANG_W-1:0] lat_t, lon_t;
  logic signed [RND_W-1:0] lat_r, lon_r;
  logic [TH_W-1:0] lat_c, lon_c;

  logic            v1;
  flags_t          f1;
  logic [TH_W-1:0] lat_th, lon_th;

  logic signed [LAT_W-1:0] lat_next;
  logic [LON_W-1:0]        lon_fold, lon_next;

  // Round half up to 2^-20 degree, clamp to [0, 90]
  always_comb begin
    lat_t = din.lat_ang + HALF;
    lon_t = din.lon_ang + HALF;
    lat_r = lat_t[ANG_W-1:ANG_FRAC-OUT_FRAC];
    lon_r = lon_t[ANG_W-1:ANG_FRAC-OUT_FRAC];
    if (lat_r[RND_W-1]) lat_c = '0;
    else if (lat_r > RND_W'(DEG90)) lat_c = DEG90;
    else lat_c = lat_r[TH_W-1:0];
    if (lon_r[RND_W-1]) lon_c = '0;
    else if (lon_r > RND_W'(DEG90)) lon_c = DEG90;
    else lon_c = lon_r[TH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1     <= din.flags;
      lat_th <= lat_c;
      lon_th <= lon_c;
    end
  end

  // Quadrant fold and special cases
  always_comb begin
    if (f1.zneg) lat_next = -LAT_W'(lat_th);
    else lat_next = LAT_W'(lat_th);
    if (f1.ypos) begin
      if (f1.xneg) lon_fold = DEG180 - LON_W'(lon_th);
      else lon_fold = LON_W'(lon_th);
    end else begin
      if (f1.xneg) lon_fold = DEG180 + LON_W'(lon_th);
      else lon_fold = DEG360 - LON_W'(lon_th);
    end
    if (lon_fold >= DEG360) lon_fold = lon_fold - DEG360;
    if (f1.zero || f1.pole) lon_next = '0;
    else if (f1.ynear) lon_next = f1.xneg ? DEG180 : '0;
    else lon_next = lon_fold;
    if (f1.zero) lat_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= din_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      latitude    <= lat_next;
      longitude   <= lon_next;
      zero_vector <= f1.zero;
    end
  end

endmodule

>>> rtl/cartesian_to_lat_lon_degrees_unit.sv
// Top level: Cartesian vector to latitude and longitude in degrees.
//
//   channel   handshake                direction  payload
//   cfg       cfg_valid / cfg_ready    in         near_zero_threshold
//   in        in_valid / in_stall      in         x_component, y_component, z_component
//   out       out_valid / out_stall    out        latitude, longitude, zero_vector
//
// One request per cycle while the output does not stall; 78 register stages:
// 10 front stages, 32 square root cells and 34 CORDIC cells, then 2 output
// stages. An output stall while out_valid is high freezes the whole pipe;
// the input register still takes one request while it is empty. Reset clears
// all valid bits and sets the threshold to 1; its square is registered from
// it in the cycle after each write.
module cartesian_to_lat_lon_degrees_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [c2ll_pkg::EPS_W-1:0]         near_zero_threshold,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [c2ll_pkg::COMP_W-1:0] x_component,
  input  logic signed [c2ll_pkg::COMP_W-1:0] y_component,
  input  logic signed [c2ll_pkg::COMP_W-1:0] z_component,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [c2ll_pkg::LAT_W-1:0]  latitude,
  output logic [c2ll_pkg::LON_W-1:0]         longitude,
  output logic                               zero_vector
);
  import c2ll_pkg::*;

  logic adv;
  logic [EPS_W-1:0] eps;
  logic [E2_W-1:0]  e2;

  logic            f_valid;
  ctx_t            f_ctx;
  logic [SQ_W-1:0] f_r2;

  logic  sq_v [SQRT_STEPS+1];
  sqrt_t sq_d [SQRT_STEPS+1];
  logic  cd_v [CORDIC_ITERS+1];
  cord_t cd_d [CORDIC_ITERS+1];

  assign adv       = !(out_valid && out_stall);
  assign cfg_ready = 1'b1;

  // Threshold register and its square
  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
      e2  <= E2_RESET;
    end else begin
      if (cfg_valid) eps <= near_zero_threshold;
      e2 <= E2_W'(eps) * E2_W'(eps);
    end
  end

  c2ll_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_component (x_component),
    .y_component (y_component),
    .z_component (z_component),
    .e2          (e2),
    .dout_valid  (f_valid),
    .dout_ctx    (f_ctx),
    .dout_r2     (f_r2)
  );

  // Square root chain on x^2 + y^2
  assign sq_v[0]      = f_valid;
  assign sq_d[0].ctx  = f_ctx;
  assign sq_d[0].rem  = f_r2;
  assign sq_d[0].root = '0;

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      c2ll_sqrt_cell #(.STEP(k)) u_step (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .din_valid  (sq_v[k]),
        .din        (sq_d[k]),
        .dout_valid (sq_v[k+1]),
        .dout       (sq_d[k+1])
      );
    end
  endgenerate

  // CORDIC operands, pre-scaled
  assign cd_v[0]         = sq_v[SQRT_STEPS];
  assign cd_d[0].flags   = sq_d[SQRT_STEPS].ctx.flags;
  assign cd_d[0].lat_x   = CORD_W'({sq_d[SQRT_STEPS].root[MAG_W-1:0], PRE_SH'(0)});
  assign cd_d[0].lat_y   = CORD_W'({sq_d[SQRT_STEPS].ctx.az, PRE_SH'(0)});
  assign cd_d[0].lat_ang = '0;
  assign cd_d[0].lon_x   = CORD_W'({sq_d[SQRT_STEPS].ctx.ax, PRE_SH'(0)});
  assign cd_d[0].lon_y   = CORD_W'({sq_d[SQRT_STEPS].ctx.ay, PRE_SH'(0)});
  assign cd_d[0].lon_ang = '0;

  genvar j;
  generate
    for (j = 0; j < CORDIC_ITERS; j++) begin : g_cordic
      c2ll_cordic_cell #(.ITER(j)) u_rot (
        .clk        (clk),
        .rst        (rst),
        .adv        (adv),
        .din_valid  (cd_v[j]),
        .din        (cd_d[j]),
        .dout_valid (cd_v[j+1]),
        .dout       (cd_d[j+1])
      );
    end
  endgenerate

  c2ll_back u_back (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .din_valid   (cd_v[CORDIC_ITERS]),
    .din         (cd_d[CORDIC_ITERS]),
    .out_valid   (out_valid),
    .latitude    (latitude),
    .longitude   (longitude),
    .zero_vector (zero_vector)
  );

endmodule
